// ----- rtl/blae_pkg.sv -----
// ----------------------------------------------------------------------------
// Bucketed list append engine: shared package
// Constants, codes and the control bundles passed between the engine's
// memory blocks and its pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package blae_pkg;

   localparam int unsigned MAX_ITEMS   = 1024;
   localparam int unsigned STORE_DEPTH = 65536;

   localparam int unsigned ITEM_W    = $clog2(MAX_ITEMS);
   localparam int unsigned POS_W     = $clog2(MAX_ITEMS + 1);
   localparam int unsigned LIMIT_W   = 11;
   localparam int unsigned CMP_W     = (POS_W > LIMIT_W) ? POS_W : LIMIT_W;
   localparam int unsigned KIND_W    = 2;
   localparam int unsigned LEN_W     = 17;
   localparam int unsigned TOTAL_W   = 17;
   localparam int unsigned SUM_W     = TOTAL_W + 1;
   localparam int unsigned FILL_W    = 17;
   localparam int unsigned START_W   = 16;
   localparam int unsigned ADDR_W    = 16;
   localparam int unsigned TX_W      = 31;
   localparam int unsigned STATUS_W  = 2;

   localparam int unsigned TOTAL_MAX = (1 << TOTAL_W) - 1;
   localparam int unsigned CAP_LIMIT = (STORE_DEPTH < TOTAL_MAX) ? STORE_DEPTH : TOTAL_MAX;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024);

   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_BUCKET = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_OVERFLOW  = 2'd2;

   typedef struct packed {
      logic               present;
      logic [START_W-1:0] start;
   } bkt_entry_type;

   typedef struct packed {
      logic              rd_en;
      logic [ITEM_W-1:0] rd_addr;
      logic              wr_en;
      logic [ITEM_W-1:0] wr_addr;
      bkt_entry_type     wr_data;
   } bkt_ctrl_type;

   typedef struct packed {
      logic              rd_en;
      logic [ITEM_W-1:0] rd_addr;
      logic              wr_en;
      logic [ITEM_W-1:0] wr_addr;
      logic [FILL_W-1:0] wr_data;
      logic              clear_start;
   } fill_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/bucketed_list_append_engine.sv -----
// ----------------------------------------------------------------------------
// Bucketed list append engine
// Lays out one bucket per item in a shared store and issues store writes
// that append transaction numbers to those buckets.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Handshake          Content
//   req_*        in          valid / stall      kind, item, length, transaction
//   rsp_*        out         valid / stall      write request, total, status
//   csr_*        in          write enable only  item limit
//
// Each transaction reads both memories in its accept cycle and is resolved
// from the registered read data, so one transaction is taken per cycle while
// the response register drains and no clear is pending; same-entry
// back-to-back accesses are forwarded. A clear-counts transaction holds off
// further requests while it is resolved and while the fill memory is swept.
// Reset needs no sweep of its own.
// A stalled response blocks the resolve stage and therefore the request side.
// ----------------------------------------------------------------------------
`default_nettype none

module bucketed_list_append_engine
   import blae_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,

   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [KIND_W-1:0]   req_kind,
   input  wire logic [ITEM_W-1:0]   req_item,
   input  wire logic [LEN_W-1:0]    req_length,
   input  wire logic [TX_W-1:0]     req_transaction,

   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic                     rsp_write_valid,
   output logic [ADDR_W-1:0]        rsp_write_address,
   output logic [TX_W-1:0]          rsp_write_value,
   output logic [TOTAL_W-1:0]       rsp_total_size,
   output logic [STATUS_W-1:0]      rsp_status,

   input  wire logic                csr_write_enable,
   input  wire logic [LIMIT_W-1:0]  csr_write_data
);

   bkt_ctrl_type      bkt_ctrl;
   bkt_entry_type     bkt_rd_data;
   fill_ctrl_type     fill_ctrl;
   logic [FILL_W-1:0] fill_rd_data;
   logic              fill_busy;

   logic [LIMIT_W-1:0] limit_ff;
   logic [POS_W-1:0]   load_pos_ff, load_pos_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               s1_valid_ff, s1_valid_in;
   logic [KIND_W-1:0]  s1_kind_ff;
   logic [ITEM_W-1:0]  s1_item_ff;
   logic [LEN_W-1:0]   s1_length_ff;
   logic [TX_W-1:0]    s1_tx_ff;
   logic               fwd_bkt_hit_ff, fwd_bkt_hit_in;
   bkt_entry_type      fwd_bkt_data_ff;
   logic               fwd_fill_hit_ff, fwd_fill_hit_in;
   logic [FILL_W-1:0]  fwd_fill_data_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_write_valid_ff, rsp_write_valid_in;
   logic [ADDR_W-1:0]  rsp_address_ff, rsp_address_in;
   logic [TX_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0] rsp_status_ff, rsp_status_in;

   logic               req_accept;
   logic               s1_fire;
   logic               load_ok;
   logic               append_ok;
   bkt_entry_type      bkt_cur;
   logic [FILL_W-1:0]  fill_cur;
   logic [SUM_W-1:0]   sum;

   assign s1_fire    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = fill_busy ||
                       (s1_valid_ff && (!s1_fire || s1_kind_ff == KIND_CLEAR));
   assign req_accept = req_valid && !req_stall;

   assign bkt_cur  = fwd_bkt_hit_ff  ? fwd_bkt_data_ff  : bkt_rd_data;
   assign fill_cur = fwd_fill_hit_ff ? fwd_fill_data_ff : fill_rd_data;

   assign load_ok   = (s1_kind_ff == KIND_LOAD) &&
                      (CMP_W'(load_pos_ff) < CMP_W'(limit_ff)) &&
                      (load_pos_ff < POS_W'(MAX_ITEMS));
   assign append_ok = (s1_kind_ff == KIND_APPEND) &&
                      (POS_W'(s1_item_ff) < load_pos_ff) && bkt_cur.present;
   assign sum       = SUM_W'(total_ff) + SUM_W'(s1_length_ff);

   always_comb begin
      bkt_ctrl.rd_en           = req_accept;
      bkt_ctrl.rd_addr         = req_item;
      bkt_ctrl.wr_en           = s1_fire && load_ok;
      bkt_ctrl.wr_addr         = load_pos_ff[ITEM_W-1:0];
      bkt_ctrl.wr_data.present = (s1_length_ff != '0);
      bkt_ctrl.wr_data.start   = total_ff[START_W-1:0];

      fill_ctrl.rd_en       = req_accept;
      fill_ctrl.rd_addr     = req_item;
      fill_ctrl.wr_en       = s1_fire && (load_ok || append_ok);
      fill_ctrl.wr_addr     = load_ok ? load_pos_ff[ITEM_W-1:0] : s1_item_ff;
      fill_ctrl.wr_data     = load_ok ? '0 : fill_cur + 1'b1;
      fill_ctrl.clear_start = s1_fire && (s1_kind_ff == KIND_CLEAR);
   end

   assign fwd_bkt_hit_in  = bkt_ctrl.wr_en && (bkt_ctrl.wr_addr == req_item);
   assign fwd_fill_hit_in = fill_ctrl.wr_en && (fill_ctrl.wr_addr == req_item);

   always_comb begin
      load_pos_in        = load_pos_ff;
      total_in           = total_ff;
      rsp_write_valid_in = 1'b0;
      rsp_address_in     = '0;
      rsp_value_in       = '0;
      rsp_status_in      = STATUS_OK;
      case (s1_kind_ff)
         KIND_LOAD: begin
            if (load_ok) begin
               load_pos_in = load_pos_ff + 1'b1;
               if (s1_length_ff != '0) begin
                  if (sum > SUM_W'(CAP_LIMIT)) begin
                     rsp_status_in = STATUS_OVERFLOW;
                  end
                  if (sum > SUM_W'(TOTAL_MAX)) begin
                     total_in = TOTAL_W'(TOTAL_MAX);
                  end else begin
                     total_in = sum[TOTAL_W-1:0];
                  end
               end
            end
         end
         KIND_APPEND: begin
            if (append_ok) begin
               rsp_write_valid_in = 1'b1;
               rsp_address_in     = bkt_cur.start + fill_cur[ADDR_W-1:0];
               rsp_value_in       = s1_tx_ff;
            end else begin
               rsp_status_in = STATUS_NO_BUCKET;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         load_pos_ff  <= '0;
         total_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         if (s1_fire) begin
            load_pos_ff <= load_pos_in;
            total_ff    <= total_in;
         end
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_kind_ff       <= req_kind;
         s1_item_ff       <= req_item;
         s1_length_ff     <= req_length;
         s1_tx_ff         <= req_transaction;
         fwd_bkt_hit_ff   <= fwd_bkt_hit_in;
         fwd_bkt_data_ff  <= bkt_ctrl.wr_data;
         fwd_fill_hit_ff  <= fwd_fill_hit_in;
         fwd_fill_data_ff <= fill_ctrl.wr_data;
      end
      if (s1_fire) begin
         rsp_write_valid_ff <= rsp_write_valid_in;
         rsp_address_ff     <= rsp_address_in;
         rsp_value_ff       <= rsp_value_in;
         rsp_status_ff      <= rsp_status_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_valid   = rsp_write_valid_ff;
   assign rsp_write_address = rsp_address_ff;
   assign rsp_write_value   = rsp_value_ff;
   assign rsp_total_size    = total_ff;
   assign rsp_status        = rsp_status_ff;

   blae_bucket_mem u_bucket_mem (
      .clock   (clock),
      .ctrl    (bkt_ctrl),
      .rd_data (bkt_rd_data)
   );

   blae_fill_mem u_fill_mem (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (fill_ctrl),
      .rd_data (fill_rd_data),
      .busy    (fill_busy)
   );

   assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_kind_ff == KIND_CLEAR) |=> (fill_busy && !s1_valid_ff))
      else $error("Clear transaction did not start the fill sweep.");

   assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (total_ff >= $past(total_ff)))
      else $error("Running total decreased.");

   assert property (@(posedge clock) disable iff (reset)
      load_pos_ff <= POS_W'(MAX_ITEMS))
      else $error("Load position beyond the item count.");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_write_valid_ff) |-> (rsp_status_ff == STATUS_OK))
      else $error("Store write issued with an error status.");

endmodule

`default_nettype wire

// ----- rtl/blae_bucket_mem.sv -----
// ----------------------------------------------------------------------------
// Bucket descriptor memory
// One entry per item holding the start offset and the present flag.
// Single write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module blae_bucket_mem
   import blae_pkg::*;
(
   input  wire logic          clock,
   input  wire bkt_ctrl_type  ctrl,
   output bkt_entry_type      rd_data
);

   bkt_entry_type store_ff [MAX_ITEMS];
   bkt_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ctrl.wr_en) begin
         store_ff[ctrl.wr_addr] <= ctrl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= store_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/blae_fill_mem.sv -----
// ----------------------------------------------------------------------------
// Fill count memory
// One fill count per item with a registered read port. A clear request
// sweeps every entry to zero, one entry per cycle, while busy is high.
// ----------------------------------------------------------------------------
`default_nettype none

module blae_fill_mem
   import blae_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fill_ctrl_type      ctrl,
   output logic [FILL_W-1:0]       rd_data,
   output logic                    busy
);

   typedef enum logic [1:0] {
      SWEEP_IDLE = 2'b01,
      SWEEP_RUN  = 2'b10
   } sweep_state_type;

   localparam logic [ITEM_W-1:0] LAST_ENTRY = ITEM_W'(MAX_ITEMS - 1);

   logic [FILL_W-1:0] store_ff [MAX_ITEMS];
   logic [FILL_W-1:0] rd_data_ff;
   sweep_state_type   state_ff, state_in;
   logic [ITEM_W-1:0] count_ff, count_in;
   logic              wr_en;
   logic [ITEM_W-1:0] wr_addr;
   logic [FILL_W-1:0] wr_data;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      case (state_ff)
         SWEEP_IDLE: begin
            count_in = '0;
            if (ctrl.clear_start) begin
               state_in = SWEEP_RUN;
            end
         end
         SWEEP_RUN: begin
            count_in = count_ff + 1'b1;
            if (count_ff == LAST_ENTRY) begin
               state_in = SWEEP_IDLE;
            end
         end
         default: begin
            state_in = SWEEP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SWEEP_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   assign busy = (state_ff == SWEEP_RUN);

   always_comb begin
      if (busy) begin
         wr_en   = 1'b1;
         wr_addr = count_ff;
         wr_data = '0;
      end else begin
         wr_en   = ctrl.wr_en;
         wr_addr = ctrl.wr_addr;
         wr_data = ctrl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.rd_en) begin
         rd_data_ff <= store_ff[ctrl.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

   assert property (@(posedge clock) disable iff (reset)
      ctrl.clear_start |-> !busy)
      else $error("Clear requested while a sweep is running.");

   assert property (@(posedge clock) disable iff (reset)
      (busy && count_ff == LAST_ENTRY) |=> !busy)
      else $error("Sweep did not stop after the last entry.");

   assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff))
      else $error("Sweep state is not one-hot.");

endmodule

`default_nettype wire

// ----- test/blae_watch.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bucketed list append engine: response watcher
// Follows every accepted request and register write. It keeps its own copy
// of the bucket layout, fill counts and item limit, and uses them to work
// out the response that each request should produce. Responses are
// compared field by field, in order, against the oldest outstanding
// prediction.
// ----------------------------------------------------------------------------

module blae_watch
   import blae_pkg::*;
(
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ITEM_W-1:0]   req_item,
   input  logic [LEN_W-1:0]    req_length,
   input  logic [TX_W-1:0]     req_transaction,

   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_write_valid,
   input  logic [ADDR_W-1:0]   rsp_write_address,
   input  logic [TX_W-1:0]     rsp_write_value,
   input  logic [TOTAL_W-1:0]  rsp_total_size,
   input  logic [STATUS_W-1:0] rsp_status,

   input  logic                csr_write_enable,
   input  logic [LIMIT_W-1:0]  csr_write_data,

   output int                  fail_count,
   output int                  outstanding
);

   typedef struct packed {
      logic                write_valid;
      logic [ADDR_W-1:0]   address;
      logic [TX_W-1:0]     value;
      logic [TOTAL_W-1:0]  total;
      logic [STATUS_W-1:0] status;
   } engine_reply_type;

   engine_reply_type owed_replies [$];

   logic [START_W-1:0] bucket_base [MAX_ITEMS];
   bit                 has_bucket [MAX_ITEMS];
   logic [FILL_W-1:0]  fill_count [MAX_ITEMS];
   int unsigned        buckets_laid;
   logic [TOTAL_W-1:0] layout_total;
   logic [LIMIT_W-1:0] item_limit;
   int                 replies_seen;

   task automatic report_mismatch(input string what);
      if (fail_count < 100) $display("%0t ns: response %0d: %s", $time, replies_seen, what);
      fail_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
   endtask

   task automatic lay_out_or_append(input logic [KIND_W-1:0] kind,
                                    input logic [ITEM_W-1:0] item,
                                    input logic [LEN_W-1:0] len,
                                    input logic [TX_W-1:0] tx,
                                    output engine_reply_type reply);
      int unsigned in_force;
      int unsigned sum;
      reply = '0;
      reply.status = STATUS_OK;
      case (kind)
         KIND_LOAD: begin
            in_force = (item_limit > MAX_ITEMS) ? MAX_ITEMS : item_limit;
            if (buckets_laid < in_force) begin
               if (len != 0) begin
                  sum = layout_total + len;
                  bucket_base[buckets_laid] = layout_total[START_W-1:0];
                  has_bucket[buckets_laid] = 1'b1;
                  if (sum > STORE_DEPTH || sum > TOTAL_MAX) reply.status = STATUS_OVERFLOW;
                  layout_total = (sum > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(sum);
               end else begin
                  has_bucket[buckets_laid] = 1'b0;
               end
               fill_count[buckets_laid] = '0;
               buckets_laid++;
            end
         end
         KIND_APPEND: begin
            if (item >= buckets_laid || !has_bucket[item]) begin
               reply.status = STATUS_NO_BUCKET;
            end else begin
               reply.write_valid = 1'b1;
               reply.address = ADDR_W'(bucket_base[item] + fill_count[item]);
               reply.value = tx;
               fill_count[item] = fill_count[item] + 1'b1;
            end
         end
         KIND_CLEAR: begin
            foreach (fill_count[i]) fill_count[i] = '0;
         end
         default: begin
         end
      endcase
      reply.total = layout_total;
   endtask

   initial begin
      fail_count = 0;
      outstanding = 0;
      replies_seen = 0;
   end

   always @(posedge clock) begin : watch
      engine_reply_type want;
      if (reset) begin
         owed_replies.delete();
         foreach (has_bucket[i]) begin
            has_bucket[i] = 1'b0;
            fill_count[i] = '0;
         end
         buckets_laid = 0;
         layout_total = '0;
         item_limit = LIMIT_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (owed_replies.size() == 0) begin
               report_mismatch("response arrived with no request outstanding");
            end else begin
               want = owed_replies.pop_front();
               check_field("write_valid", rsp_write_valid, want.write_valid);
               check_field("write_address", rsp_write_address, want.address);
               check_field("write_value", rsp_write_value, want.value);
               check_field("total_size", rsp_total_size, want.total);
               check_field("status", rsp_status, want.status);
            end
            replies_seen++;
         end
         if (csr_write_enable) item_limit = csr_write_data;
         if (req_valid && !req_stall) begin
            lay_out_or_append(req_kind, req_item, req_length, req_transaction, want);
            owed_replies.push_back(want);
         end
      end
      outstanding <= owed_replies.size();
   end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bucketed list append engine: testbench top
// Drives the engine with a directed opening, random phases under several
// item limits, a phase that lays out every bucket and runs the store to
// capacity, and a closing burst of appends. Both channels idle and stall
// at random; the watcher beside the engine predicts and compares.
// ----------------------------------------------------------------------------

module tb_top;
   import blae_pkg::*;

   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int PHASE_ITEMS = 100;
   localparam int HOLD_CYCLES = 200;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic [KIND_W-1:0]   req_kind = KIND_LOAD;
   logic [ITEM_W-1:0]   req_item = '0;
   logic [LEN_W-1:0]    req_length = '0;
   logic [TX_W-1:0]     req_transaction = '0;
   logic                rsp_stall = 1'b0;
   logic                csr_write_enable = 1'b0;
   logic [LIMIT_W-1:0]  csr_write_data = LIMIT_RESET;

   logic                req_stall;
   logic                rsp_valid;
   logic                rsp_write_valid;
   logic [ADDR_W-1:0]   rsp_write_address;
   logic [TX_W-1:0]     rsp_write_value;
   logic [TOTAL_W-1:0]  rsp_total_size;
   logic [STATUS_W-1:0] rsp_status;

   int fail_count;
   int outstanding;

   int loads_done;
   int layout_sum;
   int limit_now;
   int last_item;
   bit quiet = 1'b0;
   bit hold_request = 1'b0;

   bucketed_list_append_engine DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_item          (req_item),
      .req_length        (req_length),
      .req_transaction   (req_transaction),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value),
      .rsp_total_size    (rsp_total_size),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data)
   );

   blae_watch reply_watch (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_item          (req_item),
      .req_length        (req_length),
      .req_transaction   (req_transaction),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_write_valid   (rsp_write_valid),
      .rsp_write_address (rsp_write_address),
      .rsp_write_value   (rsp_write_value),
      .rsp_total_size    (rsp_total_size),
      .rsp_status        (rsp_status),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .fail_count        (fail_count),
      .outstanding       (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int idle_length();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic int random_len();
      int r;
      r = $urandom_range(0, 19);
      if (r < 2) return 0;
      if (r == 19) return $urandom_range(41, 255);
      return $urandom_range(1, 40);
   endfunction

   function automatic logic [TX_W-1:0] random_tx();
      return TX_W'($urandom());
   endfunction

   // Mostly laid-out buckets, with repeats of the same bucket and of the
   // newest one, so that back-to-back accesses to one entry are common.
   function automatic int pick_append_item();
      int r;
      int choice;
      r = $urandom_range(0, 99);
      choice = $urandom_range(0, MAX_ITEMS - 1);
      if (loads_done > 0) begin
         if (r < 15) choice = last_item;
         else if (r < 30) choice = loads_done - 1;
         else if (r < 85) choice = $urandom_range(0, loads_done - 1);
      end
      last_item = choice;
      return choice;
   endfunction

   task automatic offer(input logic [KIND_W-1:0] kind, input int item, input int len,
                        input logic [TX_W-1:0] tx);
      int in_force;
      in_force = (limit_now < int'(MAX_ITEMS)) ? limit_now : int'(MAX_ITEMS);
      req_valid <= 1'b1;
      req_kind <= kind;
      req_item <= ITEM_W'(item);
      req_length <= LEN_W'(len);
      req_transaction <= tx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (kind == KIND_LOAD && loads_done < in_force) begin
         loads_done++;
         layout_sum += len;
      end
      if (!quiet && $urandom_range(0, 99) < 25) begin
         req_valid <= 1'b0;
         repeat (idle_length()) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic write_limit(input int value);
      wait_drained();
      csr_write_data <= LIMIT_W'(value);
      csr_write_enable <= 1'b1;
      limit_now = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The receiver stalls in runs of random length; a long hold-off is
   // counted out here once the stimulus asks for it.
   initial begin : response_side
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 99) < 25) stall_left = idle_length();
         end
      end
   end

   initial begin
      #20ms;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      int r;
      loads_done = 0;
      layout_sum = 0;
      limit_now = LIMIT_RESET;
      last_item = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // With a limit of zero every load is ignored and nothing can be appended.
      write_limit(0);
      offer(KIND_LOAD, 0, 65535, '0);
      offer(KIND_LOAD, MAX_ITEMS - 1, 65536, '1);
      offer(KIND_APPEND, 0, 0, TX_W'(1));
      offer(KIND_UNUSED, 0, 0, '0);
      offer(KIND_CLEAR, 0, 0, '0);

      write_limit(MAX_ITEMS);
      offer(KIND_LOAD, 0, 0, '0);
      offer(KIND_LOAD, 0, 1, '0);
      offer(KIND_LOAD, 0, 3, '0);
      offer(KIND_APPEND, 0, 0, random_tx());
      offer(KIND_APPEND, 1, 0, '0);
      offer(KIND_APPEND, 1, 0, '1);
      offer(KIND_APPEND, 2, 0, 31'h2AAA_AAAA);
      offer(KIND_APPEND, 2, 0, 31'h5555_5555);
      offer(KIND_APPEND, 3, 0, random_tx());
      offer(KIND_APPEND, MAX_ITEMS - 1, 0, random_tx());
      offer(KIND_LOAD, 0, 2, '0);
      offer(KIND_APPEND, 3, 0, random_tx());
      offer(KIND_CLEAR, 0, 0, '0);
      offer(KIND_APPEND, 1, 0, random_tx());
      offer(KIND_UNUSED, MAX_ITEMS - 1, 65536, '1);

      for (int phase = 0; phase < 4; phase++) begin
         write_limit((phase == 2) ? loads_done / 2 : loads_done + $urandom_range(5, 80));
         quiet = ($urandom_range(0, 3) == 0);
         if (phase == 1) hold_request = 1'b1;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (r < 45)
               offer(KIND_LOAD, $urandom_range(0, MAX_ITEMS - 1), random_len(), random_tx());
            else if (r < 93)
               offer(KIND_APPEND, pick_append_item(), $urandom_range(0, 65536), random_tx());
            else if (r < 96)
               offer(KIND_CLEAR, $urandom_range(0, MAX_ITEMS - 1), random_len(), random_tx());
            else
               offer(KIND_UNUSED, $urandom_range(0, MAX_ITEMS - 1), random_len(), random_tx());
         end
      end

      // Lay out the remaining buckets, then take the store exactly to
      // capacity, one past it, and into saturation of the running total.
      write_limit(MAX_ITEMS);
      quiet = ($urandom_range(0, 1) == 0);
      while (loads_done < MAX_ITEMS - 3) begin
         if ($urandom_range(0, 9) == 0)
            offer(KIND_APPEND, pick_append_item(), 0, random_tx());
         else
            offer(KIND_LOAD, 0, random_len(), random_tx());
      end
      offer(KIND_LOAD, 0, STORE_DEPTH - layout_sum, '0);
      offer(KIND_LOAD, 0, 1, '0);
      offer(KIND_LOAD, 0, 65536, '0);
      offer(KIND_LOAD, 0, 7, '0);

      quiet = 1'b0;
      for (int n = 0; n < 80; n++) begin
         r = $urandom_range(0, 99);
         if (r < 50)
            offer(KIND_APPEND, $urandom_range(MAX_ITEMS - 8, MAX_ITEMS - 1), 0, random_tx());
         else if (r < 90)
            offer(KIND_APPEND, pick_append_item(), 0, random_tx());
         else if (r < 95)
            offer(KIND_LOAD, 0, random_len(), random_tx());
         else
            offer(KIND_CLEAR, 0, 0, random_tx());
      end

      wait_drained();
      repeat (16) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
